// ===== src/real_spherical_harmonic_eval_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spherical harmonic evaluator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef REAL_SPHERICAL_HARMONIC_EVAL_MACROS_SVH
`define REAL_SPHERICAL_HARMONIC_EVAL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RSHE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rshe check failed");
// next-cycle implication
`define RSHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rshe check failed");
`else
`define RSHE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RSHE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/rshe_pkg.sv =====
// ----------------------------------------------------------------------------
// rshe_pkg
// Shared types, constants and tables of the spherical harmonic evaluator.
// ----------------------------------------------------------------------------
package rshe_pkg;

    localparam int MAX_BAND     = 8;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;   // CORDIC datapath width
    localparam int QDEPTH       = 2;
    localparam int QAW          = 1;
    localparam int QCW          = 2;

    localparam logic [63:0]          INV4PI_Q62   = 64'd366986312910249100;
    localparam logic signed [CW-1:0] CORDIC_START = CW'(64'sd652032874);
    localparam logic signed [63:0]   SQRT2_Q30    = 64'sd1518500250;
    localparam logic signed [63:0]   ONE_Q32      = 64'sh1_0000_0000;

    typedef logic [1:0] t_mulmode;
    localparam t_mulmode MUL_RAW  = 2'd0;
    localparam t_mulmode MUL_SH30 = 2'd1;
    localparam t_mulmode MUL_SH32 = 2'd2;
    localparam t_mulmode MUL_SH50 = 2'd3;

    typedef struct packed {
        logic [3:0]            band;
        logic [3:0]            ord_mag;
        logic                  ord_neg;
        logic                  bad;
        logic [ANGLE_BITS-1:0] polar;
        logic [ANGLE_BITS-1:0] phase;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // (2a-1)!!
    function automatic logic [20:0] dfact_odd(input logic [3:0] a);
        logic [20:0] v;
        unique case (a)
            4'd0, 4'd1: v = 21'd1;
            4'd2: v = 21'd3;
            4'd3: v = 21'd15;
            4'd4: v = 21'd105;
            4'd5: v = 21'd945;
            4'd6: v = 21'd10395;
            4'd7: v = 21'd135135;
            4'd8: v = 21'd2027025;
            default: v = 21'd1;
        endcase
        return v;
    endfunction

endpackage

// ===== src/real_spherical_harmonic_eval.sv =====
// ----------------------------------------------------------------------------
// real_spherical_harmonic_eval
// Fixed-point real spherical harmonic Y_lm(theta, phi), queue interfaces.
// ----------------------------------------------------------------------------
// Push a request (band l, signed order m, azimuth phi, polar theta, both
// angles as fractions of a turn) while full is low; pop the Q2.30 result while
// empty is low. Requests are checked on entry and parked in a two-entry queue,
// so a new request is taken while the back end works and while a finished
// result still waits in the output register. The back end handles one request
// at a time: a 30-step CORDIC for theta, the seed and upward Legendre
// recurrence on a shared 64-bit multiplier (four 32x32 passes per product),
// the normalization from the (l+|m|)!/(l-|m|)! product through two 32-step
// square roots and a 64-step divide, and the final scaling. A rejected
// request (|m| > l or l > 8) returns zero with bad_order set. For a valid
// one the one-bit-per-cycle divider dominates the run time, since every
// recurrence step above band |m|+1 runs a division by n-|m|. The CORDIC
// for m*phi runs beside the Legendre work and adds nothing.
// ----------------------------------------------------------------------------
`include "real_spherical_harmonic_eval_macros.svh"

module real_spherical_harmonic_eval import rshe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_band,
    input  logic signed [4:0]  i_order,
    input  logic [15:0]        i_azimuth,
    input  logic [15:0]        i_polar,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_value,
    output logic               o_bad_order
);
    // request path: front classifies, queue decouples, back computes
    t_item  w_fitem;
    t_item  w_qitem;
    t_qstat w_qstat;
    logic   w_q_push;
    logic   w_q_pop;

    rshe_front u_front (
        .i_push    (push),
        .i_band    (i_band),
        .i_order   (i_order),
        .i_azimuth (i_azimuth),
        .i_polar   (i_polar),
        .i_qstat   (w_qstat),
        .o_full    (full),
        .o_q_push  (w_q_push),
        .o_item    (w_fitem)
    );

    rshe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_fitem),
        .i_pop   (w_q_pop),
        .o_item  (w_qitem),
        .o_stat  (w_qstat)
    );

    // back end owns the output register; empty reflects it directly
    rshe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_qitem),
        .i_qstat     (w_qstat),
        .o_q_pop     (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value     (o_value),
        .o_bad_order (o_bad_order)
    );

    // a rejected request always reports zero
    `RSHE_ASSERT_IMPLY(a_bad_is_zero, i_clk, i_rst_n, !empty && o_bad_order, o_value == 32'sd0)
    // back end never drains an empty queue
    `RSHE_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, w_q_pop, !w_qstat.empty)
    // a drain without a fill frees a slot
    `RSHE_ASSERT_NEXT(a_pop_frees, i_clk, i_rst_n, w_q_pop && !w_q_push, !w_qstat.full)
endmodule

// ===== src/rshe_front.sv =====
// ----------------------------------------------------------------------------
// rshe_front
// Takes requests, checks the band and order, folds the sign and forms the m*phi angle.
// ----------------------------------------------------------------------------
module rshe_front import rshe_pkg::*; (
    input  logic        i_push,
    input  logic [3:0]  i_band,
    input  logic [4:0]  i_order,
    input  logic [15:0] i_azimuth,
    input  logic [15:0] i_polar,
    input  t_qstat      i_qstat,
    output logic        o_full,
    output logic        o_q_push,
    output t_item       o_item
);
    localparam int PW = ANGLE_BITS + 5;

    logic          w_neg;
    logic [4:0]    w_mag;
    logic [PW-1:0] w_prod;

    assign w_neg  = i_order[4];
    assign w_mag  = w_neg ? (5'd0 - i_order) : i_order;
    assign w_prod = PW'(w_mag) * PW'(i_azimuth[ANGLE_BITS-1:0]);

    always_comb begin
        o_item.band    = i_band;
        o_item.ord_mag = w_mag[3:0];
        o_item.ord_neg = w_neg;
        o_item.bad     = (i_band > 4'(MAX_BAND)) || (w_mag > {1'b0, i_band});
        o_item.polar   = i_polar[ANGLE_BITS-1:0];
        o_item.phase   = w_prod[ANGLE_BITS-1:0];
    end

    assign o_full   = i_qstat.full;
    assign o_q_push = i_push && !i_qstat.full;
endmodule

// ===== src/rshe_queue.sv =====
// ----------------------------------------------------------------------------
// rshe_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module rshe_queue import rshe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_stat
);
    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));
endmodule

// ===== src/rshe_cordic.sv =====
// ----------------------------------------------------------------------------
// rshe_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, quadrant folded.
// ----------------------------------------------------------------------------
module rshe_cordic import rshe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic                  o_busy,
    output logic                  o_done,
    output logic signed [CW-1:0]  o_cos,
    output logic signed [CW-1:0]  o_sin
);
    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_i;
    logic [1:0]           r_quad;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    logic [31:0]          w_t32;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_atan;

    assign w_t32  = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_atan = $signed({{(CW-30){1'b0}}, atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_quad <= w_t32[31:30];
                r_x    <= CORDIC_START;
                r_y    <= '0;
                r_z    <= $signed({{(CW-30){1'b0}}, w_t32[29:0]});
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (r_quad)
            2'd0: begin o_cos = r_x;  o_sin = r_y;  end
            2'd1: begin o_cos = -r_y; o_sin = r_x;  end
            2'd2: begin o_cos = -r_x; o_sin = -r_y; end
            2'd3: begin o_cos = r_y;  o_sin = -r_x; end
        endcase
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

// ===== src/rshe_back.sv =====
// ----------------------------------------------------------------------------
// rshe_back
// Sequencer with shared multiplier, divider and square root units.
// ----------------------------------------------------------------------------
module rshe_back import rshe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  t_qstat             i_qstat,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [31:0] o_value,
    output logic               o_bad_order
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_TH    = 5'd1;
    localparam logic [4:0] ST_SEED  = 5'd2;
    localparam logic [4:0] ST_DF    = 5'd3;
    localparam logic [4:0] ST_P1A   = 5'd4;
    localparam logic [4:0] ST_P1B   = 5'd5;
    localparam logic [4:0] ST_RA    = 5'd6;
    localparam logic [4:0] ST_RB    = 5'd7;
    localparam logic [4:0] ST_RC    = 5'd8;
    localparam logic [4:0] ST_RD    = 5'd9;
    localparam logic [4:0] ST_DPROD = 5'd10;
    localparam logic [4:0] ST_NORM  = 5'd11;
    localparam logic [4:0] ST_SQN   = 5'd12;
    localparam logic [4:0] ST_SQX   = 5'd13;
    localparam logic [4:0] ST_KDIV  = 5'd14;
    localparam logic [4:0] ST_KV    = 5'd15;
    localparam logic [4:0] ST_TR    = 5'd16;
    localparam logic [4:0] ST_VT    = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    // sequencer
    logic [4:0]         r_state;
    logic               r_issued;
    t_item              r_it;
    logic               r_vbad;
    logic signed [63:0] r_cq, r_sq, r_p0, r_p1, r_tmp, r_t, r_v, r_tr;
    logic [4:0]         r_cnt;
    logic [3:0]         r_n;
    logic [63:0]        r_d;
    logic [4:0]         r_h;
    logic [31:0]        r_sn, r_sx;
    logic [63:0]        r_kq;
    logic               r_ovalid;
    logic               r_obad;
    logic signed [31:0] r_oval;

    // multiplier
    logic               r_mbusy, r_mdone, r_mneg;
    logic [2:0]         r_mstep;
    logic [63:0]        r_ma, r_mb;
    logic [127:0]       r_macc;
    t_mulmode           r_mmode;
    logic signed [63:0] r_mres;
    // divider
    logic               r_dbusy, r_ddone;
    logic [5:0]         r_dcnt;
    logic [63:0]        r_dq, r_ddvs;
    logic [64:0]        r_drem;
    // square root
    logic               r_sbusy, r_sdone;
    logic [4:0]         r_scnt;
    logic [63:0]        r_sv, r_sr;

    // unit requests
    logic               w_mstart, w_dstart, w_sstart, w_cstart;
    logic signed [63:0] w_ma, w_mb;
    t_mulmode           w_mmode;
    logic [63:0]        w_dvd, w_dvs, w_sv;
    logic [ANGLE_BITS-1:0] w_cang;

    logic                 c_busy, c_done;
    logic signed [CW-1:0] c_cos, c_sin;

    rshe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (w_cang),
        .o_busy  (c_busy),
        .o_done  (c_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    // derived operands
    logic [3:0]         w_rd;
    logic [63:0]        w_tmag;
    logic [63:0]        w_nval;
    logic [4:0]         w_lo, w_hi;
    logic signed [CW-1:0] w_sabs;
    logic signed [63:0] w_trig;
    logic [63:0]        w_dqs;
    logic signed [63:0] w_rdq;
    logic signed [63:0] w_seed;
    logic [4:0]         w_ksl, w_ksr;
    logic signed [31:0] w_sat;

    assign w_rd   = r_n - r_it.ord_mag;
    assign w_tmag = r_t[63] ? $unsigned(-r_t) : $unsigned(r_t);
    assign w_nval = 64'({r_it.band, 1'b1}) * INV4PI_Q62;
    assign w_lo   = 5'(r_it.band) - 5'(r_it.ord_mag) + 5'd1;
    assign w_hi   = 5'(r_it.band) + 5'(r_it.ord_mag);
    assign w_sabs = c_sin[CW-1] ? -c_sin : c_sin;
    assign w_trig = r_it.ord_neg ? 64'(c_sin) : 64'(c_cos);
    assign w_dqs  = r_dq[63] ? 64'h7FFF_FFFF_FFFF_FFFF : r_dq;
    assign w_rdq  = r_t[63] ? -$signed(w_dqs) : $signed(w_dqs);
    assign w_seed = r_it.ord_mag[0] ? -r_mres : r_mres;
    assign w_ksl  = r_h - 5'd15;
    assign w_ksr  = 5'd15 - r_h;

    always_comb begin
        if (r_v > 64'sd2147483647) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (r_v < -64'sd2147483648) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = r_v[31:0];
        end
    end

    assign o_q_pop  = (r_state == ST_IDLE) && !i_qstat.empty;
    assign w_cstart = (r_state == ST_TH) && (!r_issued || c_done);
    assign w_cang   = r_issued ? r_it.phase : r_it.polar;

    always_comb begin
        w_mstart = 1'b0;
        w_ma     = r_p0;
        w_mb     = r_sq;
        w_mmode  = MUL_RAW;
        w_dstart = 1'b0;
        w_dvd    = w_tmag + 64'(w_rd[3:1]);
        w_dvs    = 64'(w_rd);
        w_sstart = 1'b0;
        w_sv     = w_nval;
        if (!r_issued) begin
            unique case (r_state)
                ST_SEED: begin
                    w_mstart = (r_cnt < 5'(r_it.ord_mag));
                    w_mmode  = MUL_SH32;
                end
                ST_DF: begin
                    w_mstart = 1'b1;
                    w_mb     = $signed(64'(dfact_odd(r_it.ord_mag)));
                end
                ST_P1A: begin
                    w_mstart = 1'b1;
                    w_ma     = r_cq;
                    w_mb     = r_p0;
                    w_mmode  = MUL_SH32;
                end
                ST_P1B: begin
                    w_mstart = 1'b1;
                    w_ma     = r_tmp;
                    w_mb     = $signed(64'({r_it.ord_mag, 1'b1}));
                end
                ST_RA: begin
                    w_mstart = (r_n <= r_it.band);
                    w_ma     = r_cq;
                    w_mb     = r_p1;
                    w_mmode  = MUL_SH32;
                end
                ST_RB: begin
                    w_mstart = 1'b1;
                    w_ma     = r_tmp;
                    w_mb     = $signed(64'(5'({r_n, 1'b0}) - 5'd1));
                end
                ST_RC: begin
                    w_mstart = 1'b1;
                    w_mb     = $signed(64'(5'(r_n) + 5'(r_it.ord_mag) - 5'd1));
                end
                ST_RD: begin
                    w_dstart = 1'b1;
                end
                ST_DPROD: begin
                    w_mstart = (r_cnt <= w_hi);
                    w_ma     = $signed(r_d);
                    w_mb     = $signed(64'(r_cnt));
                end
                ST_SQN: begin
                    w_sstart = 1'b1;
                end
                ST_SQX: begin
                    w_sstart = 1'b1;
                    w_sv     = r_d;
                end
                ST_KDIV: begin
                    w_dstart = 1'b1;
                    w_dvd    = {r_sn, 32'b0};
                    w_dvs    = 64'(r_sx);
                end
                ST_KV: begin
                    w_mstart = 1'b1;
                    w_ma     = $signed(r_kq);
                    w_mb     = r_p1;
                    w_mmode  = MUL_SH50;
                end
                ST_TR: begin
                    w_mstart = !c_busy;
                    w_ma     = w_trig;
                    w_mb     = SQRT2_Q30;
                    w_mmode  = MUL_SH30;
                end
                ST_VT: begin
                    w_mstart = 1'b1;
                    w_ma     = r_v;
                    w_mb     = r_tr;
                    w_mmode  = MUL_SH30;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_mstart || w_dstart || w_sstart) begin
                r_issued <= 1'b1;
            end
            if ((r_state != ST_OUT) && i_pop) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_it     <= i_item;
                        r_vbad   <= i_item.bad;
                        r_v      <= '0;
                        r_issued <= 1'b0;
                        r_state  <= i_item.bad ? ST_OUT : ST_TH;
                    end
                end
                ST_TH: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (c_done) begin
                        r_cq     <= 64'(c_cos) <<< 2;
                        r_sq     <= 64'(w_sabs) <<< 2;
                        r_p0     <= ONE_Q32;
                        r_cnt    <= '0;
                        r_issued <= 1'b0;
                        r_state  <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    if (!r_issued && !w_mstart) begin
                        r_state <= ST_DF;
                    end else if (r_issued && r_mdone) begin
                        r_p0     <= r_mres;
                        r_cnt    <= r_cnt + 5'd1;
                        r_issued <= 1'b0;
                    end
                end
                ST_DF: begin
                    if (r_issued && r_mdone) begin
                        r_p0     <= w_seed;
                        r_p1     <= w_seed;
                        r_issued <= 1'b0;
                        if (r_it.band == r_it.ord_mag) begin
                            r_d     <= 64'd1;
                            r_cnt   <= w_lo;
                            r_state <= ST_DPROD;
                        end else begin
                            r_state <= ST_P1A;
                        end
                    end
                end
                ST_P1A: begin
                    if (r_issued && r_mdone) begin
                        r_tmp    <= r_mres;
                        r_issued <= 1'b0;
                        r_state  <= ST_P1B;
                    end
                end
                ST_P1B: begin
                    if (r_issued && r_mdone) begin
                        r_p1     <= r_mres;
                        r_n      <= r_it.ord_mag + 4'd2;
                        r_issued <= 1'b0;
                        r_state  <= ST_RA;
                    end
                end
                ST_RA: begin
                    if (!r_issued && !w_mstart) begin
                        r_d     <= 64'd1;
                        r_cnt   <= w_lo;
                        r_state <= ST_DPROD;
                    end else if (r_issued && r_mdone) begin
                        r_tmp    <= r_mres;
                        r_issued <= 1'b0;
                        r_state  <= ST_RB;
                    end
                end
                ST_RB: begin
                    if (r_issued && r_mdone) begin
                        r_t      <= r_mres;
                        r_issued <= 1'b0;
                        r_state  <= ST_RC;
                    end
                end
                ST_RC: begin
                    if (r_issued && r_mdone) begin
                        r_t      <= r_t - r_mres;
                        r_issued <= 1'b0;
                        r_state  <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (r_issued && r_ddone) begin
                        r_p0     <= r_p1;
                        r_p1     <= w_rdq;
                        r_n      <= r_n + 4'd1;
                        r_issued <= 1'b0;
                        r_state  <= ST_RA;
                    end
                end
                ST_DPROD: begin
                    if (!r_issued && !w_mstart) begin
                        r_h     <= '0;
                        r_state <= ST_NORM;
                    end else if (r_issued && r_mdone) begin
                        r_d      <= $unsigned(r_mres);
                        r_cnt    <= r_cnt + 5'd1;
                        r_issued <= 1'b0;
                    end
                end
                ST_NORM: begin
                    if (r_d[63:62] == 2'b00) begin
                        r_d <= r_d << 2;
                        r_h <= r_h + 5'd1;
                    end else begin
                        r_state <= ST_SQN;
                    end
                end
                ST_SQN: begin
                    if (r_issued && r_sdone) begin
                        r_sn     <= r_sr[31:0];
                        r_issued <= 1'b0;
                        r_state  <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    if (r_issued && r_sdone) begin
                        r_sx     <= r_sr[31:0];
                        r_issued <= 1'b0;
                        r_state  <= ST_KDIV;
                    end
                end
                ST_KDIV: begin
                    if (r_issued && r_ddone) begin
                        r_kq     <= (r_h <= 5'd15) ? (r_dq >> w_ksr) : (r_dq << w_ksl);
                        r_issued <= 1'b0;
                        r_state  <= ST_KV;
                    end
                end
                ST_KV: begin
                    if (r_issued && r_mdone) begin
                        r_v      <= r_mres;
                        r_issued <= 1'b0;
                        r_state  <= (r_it.ord_mag == 4'd0) ? ST_OUT : ST_TR;
                    end
                end
                ST_TR: begin
                    if (r_issued && r_mdone) begin
                        r_tr     <= r_mres;
                        r_issued <= 1'b0;
                        r_state  <= ST_VT;
                    end
                end
                ST_VT: begin
                    if (r_issued && r_mdone) begin
                        r_v      <= r_mres;
                        r_issued <= 1'b0;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || i_pop) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= w_sat;
                        r_obad   <= r_vbad;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // multiplier: four 32x32 partial products, then round / shift / saturate in the shifted modes
    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_pp;
    logic [127:0] w_ppx, w_shr;
    logic [63:0]  w_mmag;
    logic [63:0]  w_mres;

    assign w_ah = r_mstep[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh = r_mstep[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp = 64'(w_ah) * 64'(w_bh);

    always_comb begin
        unique case (r_mstep)
            3'd0:       w_ppx = {64'b0, w_pp};
            3'd1, 3'd2: w_ppx = {32'b0, w_pp, 32'b0};
            3'd3:       w_ppx = {w_pp, 64'b0};
            default:    w_ppx = '0;
        endcase
    end

    always_comb begin
        unique case (r_mmode)
            MUL_SH30: w_shr = (r_macc + (128'd1 << 29)) >> 30;
            MUL_SH32: w_shr = (r_macc + (128'd1 << 31)) >> 32;
            MUL_SH50: w_shr = (r_macc + (128'd1 << 49)) >> 50;
            MUL_RAW:  w_shr = r_macc;
        endcase
        if ((r_mmode != MUL_RAW) && (w_shr[127:63] != '0)) begin
            w_mmag = 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            w_mmag = w_shr[63:0];
        end
        w_mres = r_mneg ? (64'd0 - w_mmag) : w_mmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            if (w_mstart) begin
                r_mbusy <= 1'b1;
                r_mstep <= '0;
                r_mneg  <= w_ma[63] ^ w_mb[63];
                r_ma    <= w_ma[63] ? $unsigned(-w_ma) : $unsigned(w_ma);
                r_mb    <= w_mb[63] ? $unsigned(-w_mb) : $unsigned(w_mb);
                r_macc  <= '0;
                r_mmode <= w_mmode;
            end else if (r_mbusy) begin
                if (r_mstep != 3'd4) begin
                    r_macc  <= r_macc + w_ppx;
                    r_mstep <= r_mstep + 3'd1;
                end else begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                    r_mres  <= $signed(w_mres);
                end
            end
        end
    end

    // divider: restoring, one quotient bit per cycle
    logic [64:0] w_drs;
    logic        w_dge;

    assign w_drs = {r_drem[63:0], r_dq[63]};
    assign w_dge = (w_drs >= {1'b0, r_ddvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (w_dstart) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
                r_dq    <= w_dvd;
                r_ddvs  <= w_dvs;
                r_drem  <= '0;
            end else if (r_dbusy) begin
                r_drem <= w_dge ? (w_drs - {1'b0, r_ddvs}) : w_drs;
                r_dq   <= {r_dq[62:0], w_dge};
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    // integer square root: two radicand bits per cycle
    logic [63:0] w_sbit, w_strial;

    assign w_sbit   = 64'h4000_0000_0000_0000 >> {r_scnt, 1'b0};
    assign w_strial = r_sr + w_sbit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else begin
            r_sdone <= 1'b0;
            if (w_sstart) begin
                r_sbusy <= 1'b1;
                r_scnt  <= '0;
                r_sv    <= w_sv;
                r_sr    <= '0;
            end else if (r_sbusy) begin
                if (r_sv >= w_strial) begin
                    r_sv <= r_sv - w_strial;
                    r_sr <= (r_sr >> 1) + w_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_scnt <= r_scnt + 5'd1;
                if (r_scnt == 5'd31) begin
                    r_sbusy <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
        end
    end

    assign o_empty     = !r_ovalid;
    assign o_value     = r_oval;
    assign o_bad_order = r_obad;
endmodule

// ===== tb/rshe_result_checker.sv =====
// ----------------------------------------------------------------------------
// rshe_result_checker
// Watches both queue ports of the harmonic evaluator, computes each Y_lm in
// the block's fixed-point arithmetic and compares it with the popped result.
// ----------------------------------------------------------------------------
module rshe_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [3:0]         i_band,
    input  logic signed [4:0]  i_order,
    input  logic [15:0]        i_azimuth,
    input  logic [15:0]        i_polar,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] o_value,
    input  logic               o_bad_order,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int           HI_BAND   = 8;
    localparam int           ANG_W     = 16;
    localparam longint       X_START   = 64'sd652032874;
    localparam longint       ROOT2_Q30 = 64'sd1518500250;
    localparam logic [63:0]  RECIP_4PI = 64'd366986312910249100;

    typedef struct packed {
        logic signed [31:0] value;
        logic               bad;
    } t_harmonic;

    // arctangent of 2^-i, 2^32 per turn
    localparam longint ARCTAN [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    t_harmonic harmonic_q[$];
    int        mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = harmonic_q.size();

    // exact product, shift with rounding half away from zero, saturate
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [63:0]  ma, mb, r;
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = a < 0 ? 64'(-a) : 64'(a);
        mb  = b < 0 ? 64'(-b) : 64'(b);
        p   = {64'd0, ma} * {64'd0, mb};
        p   = (p + (128'd1 << (sh - 1))) >> sh;
        r   = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint div_nearest(longint v, longint d);
        logic [64:0] q;
        q = ({1'b0, (v < 0 ? 64'(-v) : 64'(v))} + 65'(d / 2)) / 65'(d);
        if (q > 65'h0_7FFF_FFFF_FFFF_FFFF) q = 65'h0_7FFF_FFFF_FFFF_FFFF;
        return v < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 cos/sin of an angle given as a fraction of a turn
    function automatic void cordic_turn(logic [ANG_W-1:0] ang,
                                        output longint c, output longint s);
        logic [31:0] t32;
        longint      x, y, z, dx, dy;
        t32 = 32'(ang) << (32 - ANG_W);
        z   = longint'(t32[29:0]);
        x   = X_START;
        y   = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ARCTAN[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ARCTAN[i];
            end
        end
        case (t32[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // associated Legendre P_l^a in Q32, seed then upward recurrence
    function automatic longint legendre(longint l, longint a, longint cq, longint sq);
        longint p0, p1, t, df;
        p0 = 64'sd1 <<< 32;
        df = 1;
        for (longint k = 0; k < a; k++) begin
            p0 = mul_round(p0, sq, 32);
            df = df * (2 * k + 1);
        end
        p0 = p0 * df;
        if (a % 2 == 1) p0 = -p0;
        if (l == a) return p0;
        p1 = mul_round(cq, p0, 32) * (2 * a + 1);
        for (longint n = a + 2; n <= l; n++) begin
            t  = mul_round(cq, p1, 32) * (2 * n - 1) - (n + a - 1) * p0;
            p0 = p1;
            p1 = div_nearest(t, n - a);
        end
        return p1;
    endfunction

    // normalization K in Q48
    function automatic longint norm_factor(int l, int a);
        logic [63:0] n, d, q;
        int          h;
        n = 64'(2 * l + 1) * RECIP_4PI;
        d = 1;
        for (int k = l - a + 1; k <= l + a; k++) d = d * 64'(k);
        h = 0;
        while (d < (64'd1 << 62)) begin
            d = d << 2;
            h++;
        end
        q = (floor_root(n) << 32) / floor_root(d);
        q = (h <= 15) ? (q >> (15 - h)) : (q << (h - 15));
        return longint'(q);
    endfunction

    function automatic t_harmonic predict_harmonic(logic [3:0] l, logic signed [4:0] m,
                                                   logic [15:0] phi, logic [15:0] th);
        t_harmonic res;
        int        a;
        longint    ct, st, cp, sp, p, k, v;
        a   = (m < 0) ? -int'(m) : int'(m);
        res = '0;
        if (l > HI_BAND || a > l) begin
            res.bad = 1'b1;
            return res;
        end
        cordic_turn(th, ct, st);
        if (st < 0) st = -st;
        p = legendre(longint'(l), longint'(a), ct * 4, st * 4);
        k = norm_factor(int'(l), a);
        v = mul_round(k, p, 50);
        if (a != 0) begin
            cordic_turn(ANG_W'(a * int'(phi)), cp, sp);
            v = mul_round(v, mul_round(m > 0 ? cp : sp, ROOT2_Q30, 30), 30);
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        res.value = v[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_harmonic want;
        if (!i_rst_n) begin
            harmonic_q.delete();
            mismatches <= 0;
        end else begin
            if (push && !full)
                harmonic_q.push_back(predict_harmonic(i_band, i_order, i_azimuth, i_polar));
            if (pop && !empty) begin
                if (harmonic_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result value=%0d bad=%0b", o_value, o_bad_order);
                    mismatches <= mismatches + 1;
                end else begin
                    want = harmonic_q.pop_front();
                    if (want.value !== o_value || want.bad !== o_bad_order) begin
                        if (mismatches < 10)
                            $display("mismatch: expected value=%0d bad=%0b, got value=%0d bad=%0b",
                                     want.value, want.bad, o_value, o_bad_order);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/real_spherical_harmonic_eval_tb.sv =====
// ----------------------------------------------------------------------------
// real_spherical_harmonic_eval_tb
// Directed and random requests into the harmonic evaluator with random gaps
// and output stalls; a side checker predicts every result and counts errors.
// ----------------------------------------------------------------------------
module real_spherical_harmonic_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 1750;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [3:0]         i_band;
    logic signed [4:0]  i_order;
    logic [15:0]        i_azimuth;
    logic [15:0]        i_polar;
    logic               empty;
    logic               pop;
    logic signed [31:0] o_value;
    logic               o_bad_order;
    int                 fail_count;
    int                 pending;
    logic               calm;       // no gaps and no stalls while set

    real_spherical_harmonic_eval u_dut (.*);

    rshe_result_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_band, .i_order, .i_azimuth, .i_polar,
        .empty, .pop, .o_value, .o_bad_order,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #40_000_000;
        $display("real_spherical_harmonic_eval test failed");
        $finish;
    end

    // result side: stall about 18% of cycles except in the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= calm || ($urandom_range(0, 99) >= 18);
    end

    // Drive one request and hold it until the block takes it. full is read
    // at the falling edge so the decision never races the DUT's update.
    task automatic send_request(logic [3:0] l, logic signed [4:0] m,
                                logic [15:0] phi, logic [15:0] th);
        bit taken;
        if (!calm && $urandom_range(0, 99) < 18) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_band    <= l;
        i_order   <= m;
        i_azimuth <= phi;
        i_polar   <= th;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] angles [4];
        int          a, waited;
        logic [3:0]  l;
        angles = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000};
        calm      = 1'b0;
        push      = 1'b0;
        i_band    = '0;
        i_order   = '0;
        i_azimuth = '0;
        i_polar   = '0;
        i_rst_n   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme orders per band and angle corners
        for (int b = 0; b <= 8; b += 2) begin
            send_request(4'(b), 5'(b), angles[b % 4], angles[(b + 1) % 4]);
            send_request(4'(b), -5'sd0 - 5'(b), angles[(b + 2) % 4], 16'h2AAB);
        end
        send_request(4'd8, 5'sd0, 16'hFFFF, 16'hFFFF);
        send_request(4'd8, -5'sd8, 16'h1234, 16'hC000);
        send_request(4'd7, 5'sd7, 16'hFFFF, 16'h9000);  // theta past half a turn
        send_request(4'd2, 5'sd3, 16'h1000, 16'h1000);  // |m| above l
        send_request(4'd0, -5'sd1, 16'h1000, 16'h1000);
        send_request(4'd15, 5'sd0, 16'h0000, 16'h0000); // band beyond range
        send_request(4'd9, 5'sb1_0000, 16'hFFFF, 16'hFFFF);
        send_request(4'd8, 5'sd15, 16'h5555, 16'hAAAA);

        // hold off until the pipe is empty
        push <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            calm = (i >= 600 && i < 850);
            if ($urandom_range(0, 99) < 85) begin
                // well-formed; small bands more often to keep the run short
                l = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 8))
                                                : 4'($urandom_range(0, 4));
                a = $urandom_range(0, 2 * int'(l));
                send_request(l, 5'(a - int'(l)), 16'($urandom), 16'($urandom));
            end else begin
                send_request(4'($urandom), 5'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        calm = 1'b0;
        push <= 1'b0;

        wait_drained();
        waited = 0;
        while (waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end

        if (fail_count == 0 && pending == 0)
            $display("real_spherical_harmonic_eval test passed");
        else
            $display("real_spherical_harmonic_eval test failed");
        $finish;
    end

endmodule
